[src/gvsp_pkg.sv]
// gvsp_pkg: shared types and constants of the grain voice sample player
// used by gvsp_cfg, gvsp_core, gvsp_skid and grain_voice_sample_player
package gvsp_pkg;

    // width of position + start offset, also the number of remainder steps
    localparam int SUM_W   = 29;
    // quotient bits of the envelope division (Q2.16)
    localparam int ENV_W   = 18;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_GRAIN_LENGTH   = 3'd0,
        REG_START_POSITION = 3'd1,
        REG_PLAYBACK_RATE  = 3'd2,
        REG_AMPLITUDE      = 3'd3,
        REG_FILE_LENGTH    = 3'd4,
        REG_BLOCK_LENGTH   = 3'd5
    } t_reg_idx;

    // envelope region picked before the division
    typedef enum logic [1:0] {
        ENV_ZERO,
        ENV_UNITY,
        ENV_FULL,
        ENV_DIV
    } t_env_kind;

    // configuration as seen by the datapath, lengths already clamped
    typedef struct packed {
        logic [15:0] grain_length;
        logic [23:0] start_position;
        logic [15:0] playback_rate;
        logic [15:0] amplitude;
        logic [12:0] file_length;
        logic [12:0] block_length;
    } t_cfg;

    // one result item
    typedef struct packed {
        logic signed [17:0] contribution;
        logic        [11:0] slot_index;
        logic signed [23:0] mix_out;
    } t_result;

endpackage

[src/gvsp_cfg.sv]
// gvsp_cfg: configuration registers with length clamping
// depends on gvsp_pkg
module gvsp_cfg #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    input  logic [2:0]     i_wr_index,
    input  logic [23:0]    i_wr_data,
    output logic           o_wr_ready,
    output gvsp_pkg::t_cfg o_cfg
);
    import gvsp_pkg::*;

    localparam logic [12:0] FL_MAX = 13'(STORE_DEPTH > 8191 ? 8191 : STORE_DEPTH);
    localparam logic [12:0] BL_MAX = 13'd4096;

    logic [15:0] r_grain_length;
    logic [23:0] r_start_position;
    logic [15:0] r_playback_rate;
    logic [15:0] r_amplitude;
    logic [12:0] r_file_length;
    logic [12:0] r_block_length;

    assign o_wr_ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grain_length   <= 16'd1000;
            r_start_position <= 24'd4000;
            r_playback_rate  <= 16'd4096;
            r_amplitude      <= 16'd16384;
            r_file_length    <= 13'd4096;
            r_block_length   <= 13'd512;
        end else if (i_wr_valid) begin
            unique case (t_reg_idx'(i_wr_index))
                REG_GRAIN_LENGTH:   r_grain_length   <= i_wr_data[15:0];
                REG_START_POSITION: r_start_position <= i_wr_data;
                REG_PLAYBACK_RATE:  r_playback_rate  <= i_wr_data[15:0];
                REG_AMPLITUDE:      r_amplitude      <= i_wr_data[15:0];
                REG_FILE_LENGTH:    r_file_length    <= i_wr_data[12:0];
                REG_BLOCK_LENGTH:   r_block_length   <= i_wr_data[12:0];
                default: ;
            endcase
        end
    end

    // clamp lengths into their usable ranges
    always_comb begin
        o_cfg.grain_length   = r_grain_length;
        o_cfg.start_position = r_start_position;
        o_cfg.playback_rate  = r_playback_rate;
        o_cfg.amplitude      = r_amplitude;
        if (r_file_length == 13'd0)
            o_cfg.file_length = 13'd1;
        else if (r_file_length > FL_MAX)
            o_cfg.file_length = FL_MAX;
        else
            o_cfg.file_length = r_file_length;
        if (r_block_length == 13'd0)
            o_cfg.block_length = 13'd1;
        else if (r_block_length > BL_MAX)
            o_cfg.block_length = BL_MAX;
        else
            o_cfg.block_length = r_block_length;
    end

endmodule

[src/gvsp_core.sv]
// gvsp_core: pipelined datapath, remainder and envelope division steps,
// sample store, gain multipliers and saturation; depends on gvsp_pkg
module gvsp_core #(
    parameter int STORE_DEPTH = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic                i_mode,
    input  logic [11:0]         i_addr,
    input  logic signed [15:0]  i_lval,
    input  logic [23:0]         i_time,
    input  logic [15:0]         i_gtime,
    input  logic signed [23:0]  i_mix,
    input  gvsp_pkg::t_cfg      i_cfg,
    output logic                o_valid,
    output gvsp_pkg::t_result   o_result
);
    import gvsp_pkg::*;

    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int SB  = SAMPLE_BITS;
    localparam int SHL = (SB >= 16) ? SB - 16 : 0;
    localparam int SHR = (SB >= 16) ? 0 : 16 - SB;
    localparam int SH  = SB + 14;
    localparam int P1W = SB + 17;
    localparam int P2W = SB + 36;
    localparam int NS  = SUM_W;

    typedef struct packed {
        logic                 valid;
        logic                 mode;
        logic [AW-1:0]        addr;
        logic signed [SB-1:0] sample;
        logic signed [23:0]   mix;
    } t_carry;

    typedef struct packed {
        t_carry             c;
        logic [SUM_W-1:0]   sum;
        logic [SUM_W-1:0]   time_x;
        logic [12:0]        idx_rem;
        logic [12:0]        slot_rem;
        t_env_kind          kind;
        logic [17:0]        n;
        logic [15:0]        env_rem;
        logic [ENV_W-1:0]   env_q;
    } t_step;

    // one restoring remainder step on a 13 bit divisor
    function automatic logic [12:0] rem_step(input logic [12:0] r, input logic b,
                                             input logic [12:0] d);
        logic [13:0] t;
        t = {r, b};
        if (t >= {1'b0, d})
            t = t - {1'b0, d};
        return t[12:0];
    endfunction

    // stage a: input register and sample format conversion
    t_carry              r_a;
    logic [23:0]         r_a_time;
    logic [15:0]         r_a_gtime;
    logic signed [39:0]  w_ext;
    logic signed [39:0]  w_conv;

    always_comb begin
        w_ext  = 40'(i_lval);
        w_conv = (SB >= 16) ? (w_ext <<< SHL) : (w_ext >>> SHR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
        end else if (i_en) begin
            r_a.valid  <= i_valid;
            r_a.mode   <= i_mode;
            r_a.addr   <= AW'(i_addr);
            r_a.sample <= SB'(w_conv);
            r_a.mix    <= i_mix;
            r_a_time   <= i_time;
            r_a_gtime  <= i_gtime;
        end
    end

    // stage b: read position product and envelope region
    t_carry       r_b;
    logic [23:0]  r_b_time;
    logic [39:0]  r_b_prod;
    t_env_kind    r_b_kind;
    logic [17:0]  r_b_n;
    logic [17:0]  w_g4;
    logic [17:0]  w_l3;
    logic [18:0]  w_n;
    t_env_kind    w_kind;

    always_comb begin
        w_g4   = {r_a_gtime, 2'b00};
        w_l3   = 18'(i_cfg.grain_length) * 18'd3;
        w_n    = '0;
        w_kind = ENV_UNITY;
        if (i_cfg.grain_length == 16'd0) begin
            w_kind = ENV_ZERO;
        end else if (w_g4 <= {2'b00, i_cfg.grain_length}) begin
            w_n    = {1'b0, r_a_gtime + 16'd1, 2'b00};
            w_kind = ENV_DIV;
        end else if (w_g4 >= w_l3) begin
            if (r_a_gtime > i_cfg.grain_length) begin
                w_kind = ENV_ZERO;
            end else begin
                w_n    = {1'b0, i_cfg.grain_length - r_a_gtime, 2'b00};
                w_kind = ENV_DIV;
            end
        end
        // a quotient of four or more saturates the envelope
        if (w_kind == ENV_DIV && w_n >= {1'b0, i_cfg.grain_length, 2'b00})
            w_kind = ENV_FULL;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.valid <= 1'b0;
        end else if (i_en) begin
            r_b      <= r_a;
            r_b_time <= r_a_time;
            r_b_prod <= 40'(r_a_time) * 40'(i_cfg.playback_rate);
            r_b_kind <= w_kind;
            r_b_n    <= w_n[17:0];
        end
    end

    // remainder and envelope division steps, one bit per stage
    t_step        r_st [0:NS];
    t_step        n_st [0:NS];
    logic [40:0]  w_rnd;

    always_comb begin
        logic [16:0] t;
        logic        b;
        logic        ge;
        w_rnd = {1'b0, r_b_prod} + 41'd4095;
        n_st[0].c        = r_b;
        n_st[0].sum      = w_rnd[40:12] + SUM_W'(i_cfg.start_position);
        n_st[0].time_x   = SUM_W'(r_b_time);
        n_st[0].idx_rem  = '0;
        n_st[0].slot_rem = '0;
        n_st[0].kind     = r_b_kind;
        n_st[0].n        = r_b_n;
        n_st[0].env_rem  = r_b_n[17:2];
        n_st[0].env_q    = '0;
        for (int k = 0; k < NS; k++) begin
            n_st[k+1] = r_st[k];
            n_st[k+1].idx_rem  = rem_step(r_st[k].idx_rem, r_st[k].sum[NS-1-k],
                                          i_cfg.file_length);
            n_st[k+1].slot_rem = rem_step(r_st[k].slot_rem, r_st[k].time_x[NS-1-k],
                                          i_cfg.block_length);
            if (k < ENV_W) begin
                b  = (k == 0) ? r_st[k].n[1] : ((k == 1) ? r_st[k].n[0] : 1'b0);
                t  = {r_st[k].env_rem, b};
                ge = (t >= {1'b0, i_cfg.grain_length});
                n_st[k+1].env_rem = ge ? 16'(t - {1'b0, i_cfg.grain_length}) : t[15:0];
                n_st[k+1].env_q   = {r_st[k].env_q[ENV_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NS; k++)
                r_st[k].c.valid <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k <= NS; k++)
                r_st[k] <= n_st[k];
        end
    end

    // sample store: loads and reads at the same stage keep item order
    logic signed [SB-1:0] mem [0:STORE_DEPTH-1];
    logic signed [SB-1:0] r_m_rd;
    t_carry               r_m;
    logic [11:0]          r_m_slot;
    logic [ENV_W-1:0]     r_m_env;
    logic [ENV_W-1:0]     w_env;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_st[NS].c.valid && !r_st[NS].c.mode)
                mem[r_st[NS].c.addr] <= r_st[NS].c.sample;
            r_m_rd <= mem[AW'(r_st[NS].idx_rem)];
        end
    end

    always_comb begin
        unique case (r_st[NS].kind)
            ENV_ZERO:  w_env = '0;
            ENV_UNITY: w_env = ENV_W'(65536);
            ENV_FULL:  w_env = '1;
            ENV_DIV:   w_env = r_st[NS].env_q;
            default:   w_env = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m.valid <= 1'b0;
        end else if (i_en) begin
            r_m      <= r_st[NS].c;
            r_m_slot <= r_st[NS].slot_rem[11:0];
            r_m_env  <= w_env;
        end
    end

    // gain multipliers, one per stage
    t_carry                r_p1;
    logic signed [P1W-1:0] r_p1_prod;
    logic [11:0]           r_p1_slot;
    logic [ENV_W-1:0]      r_p1_env;
    t_carry                r_p2;
    logic signed [P2W-1:0] r_p2_prod;
    logic [11:0]           r_p2_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1.valid <= 1'b0;
            r_p2.valid <= 1'b0;
        end else if (i_en) begin
            r_p1      <= r_m;
            r_p1_prod <= P1W'(r_m_rd) * P1W'($signed({1'b0, i_cfg.amplitude}));
            r_p1_slot <= r_m_slot;
            r_p1_env  <= r_m_env;
            r_p2      <= r_p1;
            r_p2_prod <= P2W'(r_p1_prod) * P2W'($signed({1'b0, r_p1_env}));
            r_p2_slot <= r_p1_slot;
        end
    end

    // scale down, saturate and mix
    logic signed [P2W-1:0] w_shf;
    logic signed [21:0]    w_cw;
    logic signed [17:0]    w_c;
    logic signed [24:0]    w_sum;

    always_comb begin
        w_shf = r_p2_prod >>> SH;
        w_cw  = w_shf[21:0];
        if (w_cw > 22'sd131071)
            w_c = 18'sd131071;
        else if (w_cw < -22'sd131072)
            w_c = -18'sd131072;
        else
            w_c = w_cw[17:0];
        w_sum = 25'(r_p2.mix) + 25'(w_c);
        o_valid = r_p2.valid;
        if (!r_p2.mode) begin
            o_result.mix_out      = r_p2.mix;
            o_result.slot_index   = '0;
            o_result.contribution = '0;
        end else begin
            if (w_sum > 25'sd8388607)
                o_result.mix_out = 24'sd8388607;
            else if (w_sum < -25'sd8388608)
                o_result.mix_out = -24'sd8388608;
            else
                o_result.mix_out = w_sum[23:0];
            o_result.slot_index   = r_p2_slot;
            o_result.contribution = w_c;
        end
    end

endmodule

[src/gvsp_skid.sv]
// gvsp_skid: output register with one skid entry
// depends on gvsp_pkg
module gvsp_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  gvsp_pkg::t_result i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output gvsp_pkg::t_result o_data
);
    import gvsp_pkg::*;

    t_result r_out;
    t_result r_sk;
    logic    r_out_valid;
    logic    r_sk_valid;

    assign o_ready = !r_sk_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // output register refills from the skid entry first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_sk_valid) begin
                r_out       <= r_sk;
                r_out_valid <= 1'b1;
                r_sk_valid  <= 1'b0;
            end else begin
                r_out       <= i_data;
                r_out_valid <= i_valid;
            end
        end else if (i_valid && !r_sk_valid) begin
            r_sk       <= i_data;
            r_sk_valid <= 1'b1;
        end
    end

endmodule

[src/grain_voice_sample_player.sv]
// grain_voice_sample_player: one granular synthesis grain voice
// depends on gvsp_pkg, gvsp_cfg, gvsp_core and gvsp_skid
//
// usage
// - input stream: tuser selects the item kind, 0 loads a sample into the
//   store, 1 plays one grain sample against the given mix value
// - output stream: one result item per input item, in input order
// - configuration channel: write register index and data while idle;
//   the channel is always ready
// - the read offset modulo, slot modulo and envelope division each resolve
//   one bit per pipeline stage
// - one item per cycle unless stalled; loads and plays may be mixed freely
// - store depth must be a power of two; a play reads the store at the same
//   stage where loads write, so it sees every load accepted before it
// - reset clears all valid bits and sets the registers to their defaults;
//   store contents are undefined until written
// - when the receiver stalls the result sits in the output register, one
//   more item goes to a skid entry, then the whole pipeline holds and
//   tready drops; nothing is lost or repeated
module grain_voice_sample_player #(
    parameter int STORE_DEPTH = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [11:0] load_address, [27:12] load_value, [51:28] sample_time,
    // [67:52] grain_time, [91:68] mix_in, [95:92] zero
    input  logic [95:0] i_s_axis_tdata,
    // [0] mode
    input  logic [0:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [23:0] mix_out, [35:24] slot_index, [53:36] contribution, [55:54] zero
    output logic [55:0] o_m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import gvsp_pkg::*;

    t_cfg    w_cfg;
    t_result w_core_res;
    t_result w_out_res;
    logic    w_core_valid;
    logic    w_en;

    gvsp_cfg #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_wr_ready (o_cfg_ready),
        .o_cfg      (w_cfg)
    );

    // pipeline advances whenever the skid entry is free
    assign o_s_axis_tready = w_en;

    gvsp_core #(
        .STORE_DEPTH (STORE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_s_axis_tvalid),
        .i_mode   (i_s_axis_tuser[0]),
        .i_addr   (i_s_axis_tdata[11:0]),
        .i_lval   (i_s_axis_tdata[27:12]),
        .i_time   (i_s_axis_tdata[51:28]),
        .i_gtime  (i_s_axis_tdata[67:52]),
        .i_mix    (i_s_axis_tdata[91:68]),
        .i_cfg    (w_cfg),
        .o_valid  (w_core_valid),
        .o_result (w_core_res)
    );

    gvsp_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_core_valid),
        .o_ready (w_en),
        .i_data  (w_core_res),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (w_out_res)
    );

    assign o_m_axis_tdata = {2'b00, w_out_res};

endmodule
